// ----- hw/rtl/ccss_pkg.sv -----
// ----------------------------------------------------------------------------
// ccss_pkg
// Types, codes and frequency table of the CPU clock switch sequencer.
// ----------------------------------------------------------------------------
package ccss_pkg;

    localparam int ROM_SLOTS = 32;
    localparam int IDX_W     = 5;
    localparam int KHZ_W     = 20;
    localparam int VDD_W     = 11;

    localparam logic [IDX_W-1:0] STANDBY_ROW = 5'd2;
    localparam logic [IDX_W-1:0] BOOT_ROW    = 5'd14;

    localparam logic [1:0] SEL_RAW = 2'd0;
    localparam logic [1:0] SEL_PLL = 2'd1;
    localparam logic [5:0] L_MAX   = 6'd33;
    localparam logic [5:0] L_MIN   = 6'd10;

    localparam logic [1:0] MODE_SET_RATE = 2'd0;
    localparam logic [1:0] MODE_COLLAPSE = 2'd1;
    localparam logic [1:0] MODE_WFI      = 2'd2;

    localparam logic [1:0] REG_STANDBY  = 2'd0;
    localparam logic [1:0] REG_COLLAPSE = 2'd1;
    localparam logic [1:0] REG_IDLE     = 2'd2;

    localparam logic [KHZ_W-1:0] STANDBY_RESET  = 20'd245000;
    localparam logic [KHZ_W-1:0] COLLAPSE_RESET = 20'd128000;
    localparam logic [KHZ_W-1:0] IDLE_RESET     = 20'd128000;

    typedef enum logic [2:0] {
        ACT_RAISE_VDD = 3'd0,
        ACT_SEL_CLOCK = 3'd1,
        ACT_SET_PLL   = 3'd2,
        ACT_PLL_OFF   = 3'd3,
        ACT_DROP_VDD  = 3'd4,
        ACT_DONE      = 3'd5
    } t_action;

    // Fixed order of the switch steps; a run enables a subset.
    typedef enum logic [2:0] {
        SLOT_RAISE   = 3'd0,
        SLOT_STANDBY = 3'd1,
        SLOT_SET_PLL = 3'd2,
        SLOT_SEL_PLL = 3'd3,
        SLOT_SEL_NEW = 3'd4,
        SLOT_PLL_OFF = 3'd5,
        SLOT_DROP    = 3'd6,
        SLOT_DONE    = 3'd7
    } t_slot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [KHZ_W-1:0] khz;
        logic [6:0]       cfg;
        logic [1:0]       sel;
        logic [5:0]       lval;
        logic [VDD_W-1:0] vdd;
    } t_row;

    function automatic t_row mk_row(logic [KHZ_W-1:0] khz, logic [6:0] cfg,
                                    logic [1:0] sel, logic [5:0] lval,
                                    logic [VDD_W-1:0] vdd);
        t_row r;
        r.khz  = khz;
        r.cfg  = cfg;
        r.sel  = sel;
        r.lval = lval;
        r.vdd  = vdd;
        return r;
    endfunction

    function automatic t_row rom_row(logic [IDX_W-1:0] idx);
        t_row r;
        unique case (idx)
            5'd0:    r = mk_row(20'd19200,  7'h00, 2'd0, 6'h00, 11'd1050);
            5'd1:    r = mk_row(20'd128000, 7'h00, 2'd2, 6'h00, 11'd1050);
            5'd2:    r = mk_row(20'd245000, 7'h40, 2'd0, 6'h00, 11'd1050);
            5'd3:    r = mk_row(20'd256000, 7'h12, 2'd0, 6'h00, 11'd1050);
            5'd4:    r = mk_row(20'd384000, 7'h00, 2'd1, 6'h0A, 11'd1050);
            5'd5:    r = mk_row(20'd422400, 7'h00, 2'd1, 6'h0B, 11'd1050);
            5'd6:    r = mk_row(20'd460800, 7'h00, 2'd1, 6'h0C, 11'd1050);
            5'd7:    r = mk_row(20'd499200, 7'h00, 2'd1, 6'h0D, 11'd1075);
            5'd8:    r = mk_row(20'd537600, 7'h00, 2'd1, 6'h0E, 11'd1100);
            5'd9:    r = mk_row(20'd576000, 7'h00, 2'd1, 6'h0F, 11'd1100);
            5'd10:   r = mk_row(20'd614400, 7'h00, 2'd1, 6'h10, 11'd1125);
            5'd11:   r = mk_row(20'd652800, 7'h00, 2'd1, 6'h11, 11'd1150);
            5'd12:   r = mk_row(20'd691200, 7'h00, 2'd1, 6'h12, 11'd1175);
            5'd13:   r = mk_row(20'd729600, 7'h00, 2'd1, 6'h13, 11'd1200);
            5'd14:   r = mk_row(20'd768000, 7'h00, 2'd1, 6'h14, 11'd1200);
            5'd15:   r = mk_row(20'd806400, 7'h00, 2'd1, 6'h15, 11'd1225);
            5'd16:   r = mk_row(20'd844800, 7'h00, 2'd1, 6'h16, 11'd1250);
            5'd17:   r = mk_row(20'd883200, 7'h00, 2'd1, 6'h17, 11'd1275);
            5'd18:   r = mk_row(20'd921600, 7'h00, 2'd1, 6'h18, 11'd1275);
            5'd19:   r = mk_row(20'd960000, 7'h00, 2'd1, 6'h19, 11'd1275);
            5'd20:   r = mk_row(20'd998400, 7'h00, 2'd1, 6'h1A, 11'd1275);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] clamp_l(logic [5:0] lv);
        logic [5:0] v;
        v = (lv > L_MAX) ? L_MAX : lv;
        v = (v < L_MIN) ? L_MIN : v;
        return v;
    endfunction

endpackage

// ----- hw/rtl/ccss_in_if.sv -----
// ----------------------------------------------------------------------------
// ccss_in_if
// Request channel: mode and requested frequency.
// ----------------------------------------------------------------------------
interface ccss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [19:0] rate_khz;

    modport source (output valid, output mode, output rate_khz, input ready);
    modport sink (input valid, input mode, input rate_khz, output ready);
endinterface

// ----- hw/rtl/ccss_out_if.sv -----
// ----------------------------------------------------------------------------
// ccss_out_if
// Action channel: one switch step per transaction.
// ----------------------------------------------------------------------------
interface ccss_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [1:0]  clock_source;
    logic [6:0]  clock_config;
    logic [5:0]  pll_l_value;
    logic [10:0] vdd_mv;
    logic        status;
    logic [19:0] previous_khz;
    logic        last;

    modport source (
        output valid, output action, output clock_source, output clock_config,
        output pll_l_value, output vdd_mv, output status, output previous_khz,
        output last, input ready
    );
    modport sink (
        input valid, input action, input clock_source, input clock_config,
        input pll_l_value, input vdd_mv, input status, input previous_khz,
        input last, output ready
    );
endinterface

// ----- hw/rtl/cpu_clock_switch_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// cpu_clock_switch_sequencer_core
// Frequency switch sequencer: table search and step sequence per request.
// ----------------------------------------------------------------------------
// Sequence: a check state, then a search of the table rows (one row
//   compare per cycle on the shared comparator) unless the target is zero
//   or unchanged, then 8 step slots in order; output stalls hold a slot.
// Throughput: one request at a time; a new one is taken once done is queued.
// Reset: 768000 kHz row made current; control and config regs to defaults.
// ----------------------------------------------------------------------------
module cpu_clock_switch_sequencer_core
    import ccss_pkg::*;
#(
    parameter int TABLE_ROWS = 21
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ccss_in_if.sink           i_in,
    ccss_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [KHZ_W-1:0]  i_cfg_data
);

    localparam int LIM = (TABLE_ROWS > ROM_SLOTS) ? ROM_SLOTS : TABLE_ROWS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIM - 1);

    t_state            r_state, n_state;
    logic [KHZ_W-1:0]  r_standby, r_collapse, r_idle;
    logic [IDX_W-1:0]  r_cur_row, n_cur_row;
    logic [IDX_W-1:0]  r_old_row, n_old_row;
    logic [IDX_W-1:0]  r_nxt_row, n_nxt_row;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [KHZ_W-1:0]  r_target, n_target;
    logic [KHZ_W-1:0]  r_prev, n_prev;
    logic              r_power, n_power;
    logic              r_status, n_status;
    logic [7:0]        r_mask, n_mask;
    t_slot             r_step, n_step;

    logic              r_out_valid, n_out_valid;
    t_action           r_action, n_action;
    logic [1:0]        r_src, n_src;
    logic [6:0]        r_ccfg, n_ccfg;
    logic [5:0]        r_lval, n_lval;
    logic [VDD_W-1:0]  r_vdd, n_vdd;
    logic              r_ostat, n_ostat;
    logic [KHZ_W-1:0]  r_oprev, n_oprev;
    logic              r_last, n_last;

    logic              in_fire, out_free, emit_go;
    logic              row_match;
    logic [KHZ_W-1:0]  cur_khz, srch_khz;
    t_row              row_old, row_new, row_sby, row_cand, row_cur;
    logic              npll, cpll, on_standby;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign emit_go  = (r_state == ST_EMIT) && out_free;

    assign row_cur  = rom_row(r_cur_row);
    assign row_sby  = rom_row(STANDBY_ROW);
    assign row_old  = rom_row(r_old_row);
    assign row_new  = rom_row(r_nxt_row);
    assign row_cand = rom_row(r_idx);

    assign cur_khz   = (r_cur_row == STANDBY_ROW) ? r_standby : row_cur.khz;
    assign srch_khz  = (r_idx == STANDBY_ROW) ? r_standby : row_cand.khz;
    assign row_match = (srch_khz == r_target);

    assign npll       = (row_cand.sel == SEL_PLL);
    assign cpll       = (row_old.sel == SEL_PLL);
    assign on_standby = (row_old.cfg == row_sby.cfg) && (row_old.sel == row_sby.sel);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_target == '0 || r_target == r_prev) n_state = ST_EMIT;
                else n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (row_match || r_idx == LAST_IDX) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_step == SLOT_DONE && out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and sequencer outputs
    always_comb begin
        n_cur_row   = r_cur_row;
        n_old_row   = r_old_row;
        n_nxt_row   = r_nxt_row;
        n_idx       = r_idx;
        n_target    = r_target;
        n_prev      = r_prev;
        n_power     = r_power;
        n_status    = r_status;
        n_mask      = r_mask;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_out.ready;
        n_action    = r_action;
        n_src       = r_src;
        n_ccfg      = r_ccfg;
        n_lval      = r_lval;
        n_vdd       = r_vdd;
        n_ostat     = r_ostat;
        n_oprev     = r_oprev;
        n_last      = r_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_prev    = cur_khz;
                    n_old_row = r_cur_row;
                    n_power   = (i_in.mode != MODE_SET_RATE);
                    n_status  = 1'b0;
                    n_idx     = '0;
                    n_step    = SLOT_RAISE;
                    unique case (i_in.mode)
                        MODE_SET_RATE: n_target = i_in.rate_khz;
                        MODE_COLLAPSE: n_target = (cur_khz > r_collapse) ? r_collapse : '0;
                        MODE_WFI:      n_target = (cur_khz > r_idle) ? r_idle : '0;
                        default:       n_target = '0;
                    endcase
                end
            end
            ST_CHECK: begin
                n_mask = 8'b1000_0000;
            end
            ST_SEARCH: begin
                if (row_match) begin
                    n_nxt_row = r_idx;
                    n_cur_row = r_idx;
                    n_mask[SLOT_RAISE]   = !r_power && (row_cand.vdd > row_old.vdd);
                    n_mask[SLOT_STANDBY] = npll ? !on_standby : cpll;
                    n_mask[SLOT_SET_PLL] = npll;
                    n_mask[SLOT_SEL_PLL] = npll;
                    n_mask[SLOT_SEL_NEW] = !npll;
                    n_mask[SLOT_PLL_OFF] = !npll && cpll;
                    n_mask[SLOT_DROP]    = !r_power && (row_cand.vdd < row_old.vdd);
                    n_mask[SLOT_DONE]    = 1'b1;
                end else if (r_idx == LAST_IDX) begin
                    n_status = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    if (r_step != SLOT_DONE) n_step = t_slot'(r_step + 3'd1);
                    if (r_mask[r_step]) begin
                        n_out_valid = 1'b1;
                        n_src       = '0;
                        n_ccfg      = '0;
                        n_lval      = '0;
                        n_vdd       = '0;
                        n_ostat     = 1'b0;
                        n_oprev     = '0;
                        n_last      = 1'b0;
                        unique case (r_step)
                            SLOT_RAISE: begin
                                n_action = ACT_RAISE_VDD;
                                n_vdd    = row_new.vdd;
                            end
                            SLOT_STANDBY: begin
                                n_action = ACT_SEL_CLOCK;
                                n_src    = row_sby.sel;
                                n_ccfg   = row_sby.cfg;
                            end
                            SLOT_SET_PLL: begin
                                n_action = ACT_SET_PLL;
                                n_lval   = clamp_l(row_new.lval);
                            end
                            SLOT_SEL_PLL: begin
                                n_action = ACT_SEL_CLOCK;
                                n_src    = SEL_PLL;
                            end
                            SLOT_SEL_NEW: begin
                                n_action = ACT_SEL_CLOCK;
                                n_src    = row_new.sel;
                                n_ccfg   = row_new.cfg;
                            end
                            SLOT_PLL_OFF: n_action = ACT_PLL_OFF;
                            SLOT_DROP: begin
                                n_action = ACT_DROP_VDD;
                                n_vdd    = row_new.vdd;
                            end
                            SLOT_DONE: begin
                                n_action = ACT_DONE;
                                n_ostat  = r_status;
                                n_oprev  = r_prev;
                                n_last   = 1'b1;
                            end
                            default: n_action = ACT_DONE;
                        endcase
                    end
                end
            end
            default: n_step = SLOT_RAISE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_row   <= BOOT_ROW;
            r_out_valid <= 1'b0;
            r_step      <= SLOT_RAISE;
            r_mask      <= '0;
            r_standby   <= STANDBY_RESET;
            r_collapse  <= COLLAPSE_RESET;
            r_idle      <= IDLE_RESET;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_mask      <= n_mask;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_STANDBY:  r_standby  <= i_cfg_data;
                    REG_COLLAPSE: r_collapse <= i_cfg_data;
                    REG_IDLE:     r_idle     <= i_cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_old_row <= n_old_row;
        r_nxt_row <= n_nxt_row;
        r_idx     <= n_idx;
        r_target  <= n_target;
        r_prev    <= n_prev;
        r_power   <= n_power;
        r_status  <= n_status;
        r_action  <= n_action;
        r_src     <= n_src;
        r_ccfg    <= n_ccfg;
        r_lval    <= n_lval;
        r_vdd     <= n_vdd;
        r_ostat   <= n_ostat;
        r_oprev   <= n_oprev;
        r_last    <= n_last;
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.action       = r_action;
    assign o_out.clock_source = r_src;
    assign o_out.clock_config = r_ccfg;
    assign o_out.pll_l_value  = r_lval;
    assign o_out.vdd_mv       = r_vdd;
    assign o_out.status       = r_ostat;
    assign o_out.previous_khz = r_oprev;
    assign o_out.last         = r_last;

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_idx <= LAST_IDX))
        else $error("search index past table end");

    a_done_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_mask[SLOT_DONE])
        else $error("run without done step");

    a_power_no_vdd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_power) |-> (!r_mask[SLOT_RAISE] && !r_mask[SLOT_DROP]))
        else $error("voltage step in power mode");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && r_step == SLOT_DONE) |=> (r_state == ST_IDLE && r_out_valid && r_last))
        else $error("done step did not close the run");

endmodule
